### src/smgr_pkg.sv
package smgr_pkg;

    // Default build parameters
    localparam int DEF_RAMP_FRAMES = 256;
    localparam int DEF_SAMPLE_BITS = 24;

    // Gain formats: registers are Q4.20, the running gains are Q4.36
    localparam int GAIN_REG_W = 24;
    localparam int GAIN_FRAC_EXT = 16;
    localparam int GAIN_W = GAIN_REG_W + GAIN_FRAC_EXT;
    localparam logic [GAIN_REG_W-1:0] GAIN_RESET = 24'h100000;

    // Frame counter
    localparam int COUNT_W = 48;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_DESKTOP_GAIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIC_GAIN = 1'd1;

    // Routing choices
    typedef enum logic [1:0] {
        ROUTE_MIX     = 2'd0,
        ROUTE_DESKTOP = 2'd1,
        ROUTE_MIC     = 2'd2,
        ROUTE_MUTE    = 2'd3
    } route_t;

endpackage

### src/stereo_mixer_gain_ramp.sv
// Channel   Dir  Signals                                Content
// s_*       in   s_tvalid s_tready s_tdata s_tuser      one stereo frame of both sources
// m_*       out  m_tvalid m_tready m_tdata              mixed stereo frame and frame count
// cfg_*     in   cfg_we cfg_index cfg_data              gain registers, write only
//
// One frame per cycle while the output side does not stall; a frame passes through the stages
// input register, gain update, partial products, and sum and saturation, in that order.
// The gain recurrence is one subtract, one rounding add and one step add per frame.
// Reset clears the pipeline, the gain state and the frame counter; gains reload on the
// first frame. Each stage moves when the one after it is empty or moving, so a stall on
// the output side only holds back the stages that are full.
module stereo_mixer_gain_ramp
    import smgr_pkg::*;
#(
    parameter int RAMP_FRAMES = DEF_RAMP_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // desktop_left, desktop_right, mic_left, mic_right (low bits first), zero padded
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // routing[1:0], desktop_present[2], mic_present[3]
    input  logic [3:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_left, out_right, frame_position (low bits first), zero padded
    output logic [((2*SAMPLE_BITS+COUNT_W+7)/8)*8-1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic [CFG_INDEX_W-1:0]            cfg_index,
    input  logic [GAIN_REG_W-1:0]             cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((2*SAMPLE_BITS+COUNT_W+7)/8)*8;
    localparam int RAMP_SHIFT = $clog2(RAMP_FRAMES);
    localparam int LEFT_W = $clog2(RAMP_FRAMES + 1);
    localparam logic [LEFT_W-1:0] RAMP_LOAD = LEFT_W'(RAMP_FRAMES);
    localparam logic signed [GAIN_W:0] STEP_BIAS = (GAIN_W+1)'((1 << RAMP_SHIFT) - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    logic [GAIN_REG_W-1:0] desktop_gain_reg;
    logic [GAIN_REG_W-1:0] mic_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desktop_gain_reg <= GAIN_RESET;
            mic_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DESKTOP_GAIN: desktop_gain_reg <= cfg_data;
                REG_MIC_GAIN:     mic_gain_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage handshakes
    logic in_v_reg, p_v_reg, q_v_reg, o_v_reg;
    logic o_ready, q_ready, p_ready, in_ready;
    logic fire_in, move_p, move_q, move_o;

    assign o_ready  = !o_v_reg || m_tready;
    assign q_ready  = !q_v_reg || o_ready;
    assign p_ready  = !p_v_reg || q_ready;
    assign in_ready = !in_v_reg || p_ready;
    assign s_tready = in_ready;
    assign fire_in  = s_tvalid && in_ready;
    assign move_p   = in_v_reg && p_ready;
    assign move_q   = p_v_reg && q_ready;
    assign move_o   = q_v_reg && o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (fire_in)
                in_v_reg <= 1'b1;
            else if (move_p)
                in_v_reg <= 1'b0;
            if (move_p)
                p_v_reg <= 1'b1;
            else if (move_q)
                p_v_reg <= 1'b0;
            if (move_q)
                q_v_reg <= 1'b1;
            else if (move_o)
                q_v_reg <= 1'b0;
            if (move_o)
                o_v_reg <= 1'b1;
            else if (m_tready)
                o_v_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Input register; absent sources are zeroed here
    route_t                in_route_reg;
    logic signed [SB-1:0]  in_dl_reg, in_dr_reg, in_ml_reg, in_mr_reg;

    always_ff @(posedge clk)
    begin
        if (fire_in)
        begin
            in_route_reg <= route_t'(s_tuser[1:0]);
            in_dl_reg <= s_tuser[2] ? s_tdata[SB-1:0] : '0;
            in_dr_reg <= s_tuser[2] ? s_tdata[2*SB-1:SB] : '0;
            in_ml_reg <= s_tuser[3] ? s_tdata[3*SB-1:2*SB] : '0;
            in_mr_reg <= s_tuser[3] ? s_tdata[4*SB-1:3*SB] : '0;
        end
    end

    // ---------------------------------------------------------------
    // Gain state
    logic [GAIN_W-1:0]       dnow_reg, mnow_reg, dgoal_reg, mgoal_reg;
    logic signed [GAIN_W:0]  dstep_reg, mstep_reg;
    logic [LEFT_W-1:0]       ramp_left_reg;
    route_t                  route_eff_reg;
    logic                    primed_reg;
    logic [COUNT_W-1:0]      frame_cnt_reg;

    logic [GAIN_W-1:0]       dnow_next, mnow_next, dgoal_next, mgoal_next;
    logic signed [GAIN_W:0]  dstep_next, mstep_next;
    logic [LEFT_W-1:0]       ramp_left_next;
    route_t                  route_eff_next;
    logic [COUNT_W-1:0]      frame_cnt_next;

    logic [GAIN_W-1:0]       tgt_d, tgt_m, dmix, mmix;
    logic signed [GAIN_W:0]  ddiff, mdiff, dsum, msum;

    // Targets for the routing of the frame in the input register
    always_comb
    begin
        case (in_route_reg)
            ROUTE_MIX:
            begin
                tgt_d = {desktop_gain_reg, {GAIN_FRAC_EXT{1'b0}}};
                tgt_m = {mic_gain_reg, {GAIN_FRAC_EXT{1'b0}}};
            end
            ROUTE_DESKTOP:
            begin
                tgt_d = {desktop_gain_reg, {GAIN_FRAC_EXT{1'b0}}};
                tgt_m = '0;
            end
            ROUTE_MIC:
            begin
                tgt_d = '0;
                tgt_m = {mic_gain_reg, {GAIN_FRAC_EXT{1'b0}}};
            end
            default:
            begin
                tgt_d = '0;
                tgt_m = '0;
            end
        endcase
    end

    // Routing change, mix gain selection and ramp advance
    always_comb
    begin
        dnow_next = dnow_reg;
        mnow_next = mnow_reg;
        dgoal_next = dgoal_reg;
        mgoal_next = mgoal_reg;
        dstep_next = dstep_reg;
        mstep_next = mstep_reg;
        ramp_left_next = ramp_left_reg;
        route_eff_next = route_eff_reg;
        ddiff = $signed({1'b0, tgt_d}) - $signed({1'b0, dnow_reg});
        mdiff = $signed({1'b0, tgt_m}) - $signed({1'b0, mnow_reg});

        if (!primed_reg)
        begin
            route_eff_next = in_route_reg;
            dgoal_next = tgt_d;
            mgoal_next = tgt_m;
            dnow_next = tgt_d;
            mnow_next = tgt_m;
            dstep_next = '0;
            mstep_next = '0;
            ramp_left_next = '0;
        end
        else if (in_route_reg != route_eff_reg)
        begin
            route_eff_next = in_route_reg;
            dgoal_next = tgt_d;
            mgoal_next = tgt_m;
            if (dnow_reg == tgt_d && mnow_reg == tgt_m)
            begin
                dstep_next = '0;
                mstep_next = '0;
                ramp_left_next = '0;
            end
            else
            begin
                // shift right with truncation toward zero
                dstep_next = $signed(ddiff + (ddiff[GAIN_W] ? STEP_BIAS : '0)) >>> RAMP_SHIFT;
                mstep_next = $signed(mdiff + (mdiff[GAIN_W] ? STEP_BIAS : '0)) >>> RAMP_SHIFT;
                ramp_left_next = RAMP_LOAD;
            end
        end

        // this frame mixes with the gains before the advance
        dmix = dnow_next;
        mmix = mnow_next;

        dsum = $signed({1'b0, dnow_next}) + dstep_next;
        msum = $signed({1'b0, mnow_next}) + mstep_next;
        if (ramp_left_next != '0)
        begin
            if (ramp_left_next == LEFT_W'(1))
            begin
                dnow_next = dgoal_next;
                mnow_next = mgoal_next;
            end
            else
            begin
                dnow_next = dsum[GAIN_W-1:0];
                mnow_next = msum[GAIN_W-1:0];
            end
            ramp_left_next = ramp_left_next - LEFT_W'(1);
        end

        frame_cnt_next = (frame_cnt_reg == COUNT_MAX) ? frame_cnt_reg
                                                      : frame_cnt_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dnow_reg <= '0;
            mnow_reg <= '0;
            dgoal_reg <= '0;
            mgoal_reg <= '0;
            dstep_reg <= '0;
            mstep_reg <= '0;
            ramp_left_reg <= '0;
            route_eff_reg <= ROUTE_MIX;
            primed_reg <= 1'b0;
            frame_cnt_reg <= '0;
        end
        else if (move_p)
        begin
            dnow_reg <= dnow_next;
            mnow_reg <= mnow_next;
            dgoal_reg <= dgoal_next;
            mgoal_reg <= mgoal_next;
            dstep_reg <= dstep_next;
            mstep_reg <= mstep_next;
            ramp_left_reg <= ramp_left_next;
            route_eff_reg <= route_eff_next;
            primed_reg <= 1'b1;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Gain stage register: samples plus the gains for this frame
    logic [GAIN_W-1:0]      p_gd_reg, p_gm_reg;
    logic signed [SB-1:0]   p_dl_reg, p_dr_reg, p_ml_reg, p_mr_reg;
    logic [COUNT_W-1:0]     p_pos_reg;

    always_ff @(posedge clk)
    begin
        if (move_p)
        begin
            p_gd_reg <= dmix;
            p_gm_reg <= mmix;
            p_dl_reg <= in_dl_reg;
            p_dr_reg <= in_dr_reg;
            p_ml_reg <= in_ml_reg;
            p_mr_reg <= in_mr_reg;
            p_pos_reg <= frame_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Partial products: gain split into upper 24 and lower 16 bits
    logic signed [GAIN_REG_W:0]     gdh, gmh;
    logic signed [GAIN_FRAC_EXT:0]  gdl, gml;
    logic signed [SB+GAIN_REG_W:0]     q_ldh_reg, q_lmh_reg, q_rdh_reg, q_rmh_reg;
    logic signed [SB+GAIN_FRAC_EXT:0]  q_ldl_reg, q_lml_reg, q_rdl_reg, q_rml_reg;
    logic [COUNT_W-1:0]             q_pos_reg;

    assign gdh = $signed({1'b0, p_gd_reg[GAIN_W-1:GAIN_FRAC_EXT]});
    assign gmh = $signed({1'b0, p_gm_reg[GAIN_W-1:GAIN_FRAC_EXT]});
    assign gdl = $signed({1'b0, p_gd_reg[GAIN_FRAC_EXT-1:0]});
    assign gml = $signed({1'b0, p_gm_reg[GAIN_FRAC_EXT-1:0]});

    always_ff @(posedge clk)
    begin
        if (move_q)
        begin
            q_ldh_reg <= p_dl_reg * gdh;
            q_lmh_reg <= p_ml_reg * gmh;
            q_rdh_reg <= p_dr_reg * gdh;
            q_rmh_reg <= p_mr_reg * gmh;
            q_ldl_reg <= p_dl_reg * gdl;
            q_lml_reg <= p_ml_reg * gml;
            q_rdl_reg <= p_dr_reg * gdl;
            q_rml_reg <= p_mr_reg * gml;
            q_pos_reg <= p_pos_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sum, floor at sample precision, saturate
    function automatic logic [SB-1:0] sat_sample(input logic signed [SB+6:0] v);
        logic ovf;
        ovf = (v[SB+6:SB-1] != {8{1'b0}}) && (v[SB+6:SB-1] != {8{1'b1}});
        if (ovf)
            sat_sample = v[SB+6] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        else
            sat_sample = v[SB-1:0];
    endfunction

    logic signed [SB+GAIN_REG_W+1:0]    hi_l, hi_r;
    logic signed [SB+GAIN_FRAC_EXT+1:0] lo_l, lo_r;
    logic signed [SB+GAIN_W+2:0]        sum_l, sum_r;
    logic [SB-1:0]                      o_l_reg, o_r_reg;
    logic [COUNT_W-1:0]                 o_pos_reg;

    assign hi_l = {q_ldh_reg[SB+GAIN_REG_W], q_ldh_reg} + {q_lmh_reg[SB+GAIN_REG_W], q_lmh_reg};
    assign hi_r = {q_rdh_reg[SB+GAIN_REG_W], q_rdh_reg} + {q_rmh_reg[SB+GAIN_REG_W], q_rmh_reg};
    assign lo_l = {q_ldl_reg[SB+GAIN_FRAC_EXT], q_ldl_reg}
                + {q_lml_reg[SB+GAIN_FRAC_EXT], q_lml_reg};
    assign lo_r = {q_rdl_reg[SB+GAIN_FRAC_EXT], q_rdl_reg}
                + {q_rml_reg[SB+GAIN_FRAC_EXT], q_rml_reg};
    assign sum_l = $signed({hi_l[SB+GAIN_REG_W+1], hi_l, {GAIN_FRAC_EXT{1'b0}}})
                 + $signed({{(GAIN_REG_W+1){lo_l[SB+GAIN_FRAC_EXT+1]}}, lo_l});
    assign sum_r = $signed({hi_r[SB+GAIN_REG_W+1], hi_r, {GAIN_FRAC_EXT{1'b0}}})
                 + $signed({{(GAIN_REG_W+1){lo_r[SB+GAIN_FRAC_EXT+1]}}, lo_r});

    always_ff @(posedge clk)
    begin
        if (move_o)
        begin
            o_l_reg <= sat_sample(sum_l[SB+GAIN_W+2:GAIN_W-4]);
            o_r_reg <= sat_sample(sum_r[SB+GAIN_W+2:GAIN_W-4]);
            o_pos_reg <= q_pos_reg;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata = OUT_TDATA_W'({o_pos_reg, o_r_reg, o_l_reg});

    // ---------------------------------------------------------------
    // Checks
    a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_left_reg <= RAMP_LOAD)
        else $error("ramp count beyond ramp length");

    a_idle_on_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (ramp_left_reg == '0) |-> (dnow_reg == dgoal_reg && mnow_reg == mgoal_reg))
        else $error("gains off target with no ramp running");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (move_p && frame_cnt_reg != COUNT_MAX) |=>
            (frame_cnt_reg == $past(frame_cnt_reg) + COUNT_W'(1)))
        else $error("frame counter did not advance by one");

    a_unprimed_count: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (frame_cnt_reg == '0))
        else $error("frames counted before first frame");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output register empty");

endmodule

### sim/stereo_mixer_gain_ramp_checker.sv
`timescale 1ns / 1ps

// Watches the frame, result and register ports, predicts every mixed frame and
// compares each output beat against the oldest prediction.
module stereo_mixer_gain_ramp_checker
    import smgr_pkg::*;
#(
    parameter int RAMP_FRAMES = DEF_RAMP_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    input  logic                                       s_tready,
    // desktop_left, desktop_right, mic_left, mic_right (low bits first), zero padded
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
    // routing[1:0], desktop_present[2], mic_present[3]
    input  logic [3:0]                                 s_tuser,
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    // out_left, out_right, frame_position (low bits first), zero padded
    input  logic [((2*SAMPLE_BITS+COUNT_W+7)/8)*8-1:0] m_tdata,
    input  logic                                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]                     cfg_index,
    input  logic [GAIN_REG_W-1:0]                      cfg_data,
    output int                                         mismatches,
    output int                                         frames_in_flight
);

    localparam int SB = SAMPLE_BITS;
    localparam int S_W = ((4*SB+7)/8)*8;
    localparam int M_W = ((2*SB+COUNT_W+7)/8)*8;
    localparam int STEP_SHIFT = $clog2(RAMP_FRAMES);
    localparam int GAIN_FRAC = GAIN_W - 4;  // Q4.36
    localparam int ACC_W = SB + GAIN_W + 2;
    localparam longint PEAK_POS = (64'sd1 <<< (SB-1)) - 1;
    localparam longint PEAK_NEG = -PEAK_POS - 1;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [SB-1:0]      left;
        logic [SB-1:0]      right;
        logic [COUNT_W-1:0] pos;
    } mix_beat_t;

    mix_beat_t mix_expect_q[$];

    // shadow of the gain registers
    logic [GAIN_REG_W-1:0] dsk_reg;
    logic [GAIN_REG_W-1:0] mic_reg;

    // gain and ramp state, Q4.36
    logic [GAIN_W-1:0]        dsk_now;
    logic [GAIN_W-1:0]        mic_now;
    logic [GAIN_W-1:0]        dsk_goal;
    logic [GAIN_W-1:0]        mic_goal;
    logic signed [GAIN_W:0]   dsk_step;
    logic signed [GAIN_W:0]   mic_step;
    int                       ramp_left;
    route_t                   route_live;
    bit                       primed;
    logic [COUNT_W-1:0]       frame_count;

    // targets for a routing: register widened to Q4.36, or silence
    function automatic void aim_gains(route_t route);
        dsk_goal = (route == ROUTE_MIX || route == ROUTE_DESKTOP) ?
                   {dsk_reg, {GAIN_FRAC_EXT{1'b0}}} : '0;
        mic_goal = (route == ROUTE_MIX || route == ROUTE_MIC) ?
                   {mic_reg, {GAIN_FRAC_EXT{1'b0}}} : '0;
    endfunction

    // per-frame step, difference shifted down and truncated toward zero
    function automatic logic signed [GAIN_W:0] ramp_step(logic [GAIN_W-1:0] goal,
                                                         logic [GAIN_W-1:0] now);
        logic signed [GAIN_W:0] diff;
        diff = $signed({1'b0, goal}) - $signed({1'b0, now});
        if (diff < 0)
            return -((-diff) >>> STEP_SHIFT);
        return diff >>> STEP_SHIFT;
    endfunction

    // full-precision weighted sum, floored to sample precision, then clipped
    function automatic logic [SB-1:0] mix_sample(logic signed [SB-1:0] dsk,
                                                 logic signed [SB-1:0] mic,
                                                 logic [GAIN_W-1:0] g_dsk,
                                                 logic [GAIN_W-1:0] g_mic);
        logic signed [ACC_W-1:0] acc;
        acc = dsk * $signed({1'b0, g_dsk}) + mic * $signed({1'b0, g_mic});
        acc = acc >>> GAIN_FRAC;
        if (acc > PEAK_POS)
            acc = PEAK_POS;
        if (acc < PEAK_NEG)
            acc = PEAK_NEG;
        return acc[SB-1:0];
    endfunction

    task automatic predict_frame(input logic [S_W-1:0] data, input logic [3:0] user);
        route_t                route;
        logic signed [SB-1:0]  dl;
        logic signed [SB-1:0]  dr;
        logic signed [SB-1:0]  ml;
        logic signed [SB-1:0]  mr;
        mix_beat_t             want;
        route = route_t'(user[1:0]);
        dl = user[2] ? data[0 +: SB] : '0;
        dr = user[2] ? data[SB +: SB] : '0;
        ml = user[3] ? data[2*SB +: SB] : '0;
        mr = user[3] ? data[3*SB +: SB] : '0;

        // first frame loads the gains, a new routing starts a ramp
        if (!primed)
        begin
            route_live = route;
            aim_gains(route);
            dsk_now = dsk_goal;
            mic_now = mic_goal;
            ramp_left = 0;
            primed = 1'b1;
        end
        else if (route != route_live)
        begin
            route_live = route;
            aim_gains(route);
            if (dsk_now == dsk_goal && mic_now == mic_goal)
                ramp_left = 0;
            else
            begin
                dsk_step = ramp_step(dsk_goal, dsk_now);
                mic_step = ramp_step(mic_goal, mic_now);
                ramp_left = RAMP_FRAMES;
            end
        end

        want.left = mix_sample(dl, ml, dsk_now, mic_now);
        want.right = mix_sample(dr, mr, dsk_now, mic_now);

        // ramp moves after the mix; last ramp frame lands on the goal
        if (ramp_left != 0)
        begin
            dsk_now = dsk_now + GAIN_W'(dsk_step);
            mic_now = mic_now + GAIN_W'(mic_step);
            ramp_left--;
            if (ramp_left == 0)
            begin
                dsk_now = dsk_goal;
                mic_now = mic_goal;
            end
        end

        if (frame_count != COUNT_MAX)
            frame_count++;
        want.pos = frame_count;
        mix_expect_q.push_back(want);
    endtask

    task automatic check_beat(input logic [M_W-1:0] data);
        mix_beat_t          want;
        logic [SB-1:0]      got_l;
        logic [SB-1:0]      got_r;
        logic [COUNT_W-1:0] got_pos;
        got_l = data[0 +: SB];
        got_r = data[SB +: SB];
        got_pos = data[2*SB +: COUNT_W];
        if (mix_expect_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("ERROR: unexpected beat left=%0d right=%0d position=%0d",
                         $signed(got_l), $signed(got_r), got_pos);
            return;
        end
        want = mix_expect_q.pop_front();
        if (got_l !== want.left || got_r !== want.right || got_pos !== want.pos)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("ERROR: beat %0d: left %0d/%0d right %0d/%0d position %0d/%0d",
                         want.pos, $signed(want.left), $signed(got_l),
                         $signed(want.right), $signed(got_r), want.pos, got_pos);
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_expect_q.delete();
            dsk_reg = GAIN_RESET;
            mic_reg = GAIN_RESET;
            dsk_now = '0;
            mic_now = '0;
            dsk_goal = '0;
            mic_goal = '0;
            dsk_step = '0;
            mic_step = '0;
            ramp_left = 0;
            route_live = ROUTE_MIX;
            primed = 1'b0;
            frame_count = '0;
            mismatches = 0;
            frames_in_flight = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DESKTOP_GAIN)
                    dsk_reg = cfg_data;
                else if (cfg_index == REG_MIC_GAIN)
                    mic_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_frame(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_beat(m_tdata);
            frames_in_flight = mix_expect_q.size();
        end
    end

endmodule

### sim/tb_stereo_mixer_gain_ramp.sv
`timescale 1ns / 1ps

module tb_stereo_mixer_gain_ramp
    import smgr_pkg::*;
();

    localparam int SB = DEF_SAMPLE_BITS;
    localparam int S_W = ((4*SB+7)/8)*8;
    localparam int M_W = ((2*SB+COUNT_W+7)/8)*8;
    localparam int RAMP_LEN = DEF_RAMP_FRAMES;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_FRAMES = 30;
    localparam int GAIN_PHASES = 10;
    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] S_ONE = 1;
    localparam logic [GAIN_REG_W-1:0] GAIN_TOP = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // desktop_left, desktop_right, mic_left, mic_right (low bits first), zero padded
    logic [S_W-1:0]         s_tdata = '0;
    // routing[1:0], desktop_present[2], mic_present[3]
    logic [3:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // out_left, out_right, frame_position (low bits first), zero padded
    logic [M_W-1:0]         m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [GAIN_REG_W-1:0]  cfg_data = '0;

    int mismatches;
    int frames_in_flight;
    int idle_cycles = 0;
    bit tx_calm = 1'b1;
    bit rx_calm = 1'b0;

    stereo_mixer_gain_ramp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stereo_mixer_gain_ramp_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .frames_in_flight (frames_in_flight)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // end the run if no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side: random stall before each beat, with calm stretches
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // full scale, silence, tiny and random values
    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return '1;
            4: return SB'($signed($urandom_range(0, 511)) - 256);
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic send_frame(input route_t route, input logic [SB-1:0] dl,
                              input logic [SB-1:0] dr, input logic [SB-1:0] ml,
                              input logic [SB-1:0] mr, input bit dsk_on, input bit mic_on);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= S_W'({mr, ml, dr, dl});
        s_tuser <= {mic_on, dsk_on, route};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic random_frame(input route_t route);
        send_frame(route, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
    endtask

    // drop valid and wait until every frame has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (frames_in_flight == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [CFG_INDEX_W-1:0] index,
                              input logic [GAIN_REG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_REG_W-1:0] dsk_gain,
                              input logic [GAIN_REG_W-1:0] mic_gain);
        if ($urandom_range(0, 1) == 0)
        begin
            write_gain(REG_DESKTOP_GAIN, dsk_gain);
            write_gain(REG_MIC_GAIN, mic_gain);
        end
        else
        begin
            write_gain(REG_MIC_GAIN, mic_gain);
            write_gain(REG_DESKTOP_GAIN, dsk_gain);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // runs of one routing, mostly short, some long enough to finish a ramp
    task automatic gain_phase(input logic [GAIN_REG_W-1:0] dsk_gain,
                              input logic [GAIN_REG_W-1:0] mic_gain);
        int     sent;
        int     run_len;
        route_t route;
        settle();
        load_gains(dsk_gain, mic_gain);
        sent = 0;
        while (sent < PHASE_FRAMES)
        begin
            route = route_t'($urandom_range(0, 3));
            run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(RAMP_LEN, RAMP_LEN + 40)
                                                   : $urandom_range(1, 24);
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat (run_len) random_frame(route);
            sent += run_len;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unity gains: first frame loads, clipping, absent sources
        send_frame(ROUTE_MIX, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, 1'b1);
        send_frame(ROUTE_MIX, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1, 1'b1);
        send_frame(ROUTE_MIX, S_MAX, S_MIN, S_MAX, S_MIN, 1'b0, 1'b1);
        send_frame(ROUTE_MIX, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, 1'b0);
        send_frame(ROUTE_MIX, '1, '1, '1, '1, 1'b0, 1'b0);
        // routing change: this frame keeps the old gains, ramp starts
        send_frame(ROUTE_DESKTOP, S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1);
        send_frame(ROUTE_DESKTOP, '1, S_ONE, S_MIN, S_MAX, 1'b1, 1'b1);
        random_frame(ROUTE_DESKTOP);
        // change in the middle of a ramp restarts it
        send_frame(ROUTE_MIC, S_MIN, S_MIN, S_MAX, S_MIN, 1'b1, 1'b1);
        random_frame(ROUTE_MIC);
        send_frame(ROUTE_MUTE, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, 1'b1);
        random_frame(ROUTE_MUTE);

        // let the ramp to silence run out
        tx_calm = 1'b0;
        repeat (RAMP_LEN + 4) random_frame(ROUTE_MUTE);

        // loud desktop, silent mic
        settle();
        load_gains(GAIN_TOP, '0);
        tx_calm = 1'b1;
        // same routing after a register write stays ignored
        send_frame(ROUTE_MUTE, S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1);
        // targets already equal to the gains: no ramp
        send_frame(ROUTE_MIC, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, 1'b1);
        send_frame(ROUTE_MIX, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, 1'b1);
        // first ramp steps are tiny: floor toward minus infinity shows
        send_frame(ROUTE_MIX, S_ONE, '1, S_ONE, '1, 1'b1, 1'b1);
        send_frame(ROUTE_MIX, S_MAX, S_MIN, '0, '0, 1'b1, 1'b1);
        // same goals, gains not there yet: ramp restarts
        send_frame(ROUTE_DESKTOP, S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1);
        random_frame(ROUTE_DESKTOP);

        // random traffic over a set of gain settings, extremes first
        for (int p = 0; p < GAIN_PHASES; p++)
        begin
            case (p)
                0: gain_phase(GAIN_TOP, GAIN_TOP);
                1: gain_phase('0, '0);
                2: gain_phase(GAIN_RESET, '0);
                3: gain_phase('0, GAIN_TOP);
                4: gain_phase(GAIN_REG_W'(1), GAIN_RESET);
                5: gain_phase(GAIN_REG_W'($urandom_range(0, GAIN_RESET)),
                              GAIN_REG_W'($urandom_range(0, GAIN_RESET)));
                default: gain_phase(GAIN_REG_W'($urandom), GAIN_REG_W'($urandom));
            endcase
        end

        settle();
        if (mismatches == 0 && frames_in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
